/* src/c6502_pkg.sv */
package c6502_pkg;
    localparam int unsigned PcW = 16;
    localparam int unsigned ByteW = 8;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDataW = 16;

    localparam logic [15:0] DefStartPc = 16'h0000;
    localparam logic [7:0] DefStartSp = 8'd253;
    localparam logic [7:0] DefStartStatus = 8'd36;
    localparam logic [7:0] DefStartY = 8'd0;

    localparam logic [1:0] CFG_START_PC = 2'd0;
    localparam logic [1:0] CFG_START_SP = 2'd1;
    localparam logic [1:0] CFG_START_STATUS = 2'd2;
    localparam logic [1:0] CFG_START_Y = 2'd3;

    localparam logic [2:0] KIND_READ = 3'd0;
    localparam logic [2:0] KIND_WRITE = 3'd1;
    localparam logic [2:0] KIND_DONE = 3'd2;
    localparam logic [2:0] KIND_HALT = 3'd3;
    localparam logic [2:0] KIND_UNEXP = 3'd4;

    localparam logic [7:0] OP_CLC = 8'h18;
    localparam logic [7:0] OP_SEC = 8'h38;
    localparam logic [7:0] OP_NOP = 8'hEA;
    localparam logic [7:0] OP_JMP = 8'h4C;
    localparam logic [7:0] OP_JMPI = 8'h6C;
    localparam logic [7:0] OP_JSR = 8'h20;
    localparam logic [7:0] OP_LDXI = 8'hA2;
    localparam logic [7:0] OP_LDXZ = 8'hA6;
    localparam logic [7:0] OP_LDXZY = 8'hB6;
    localparam logic [7:0] OP_LDXA = 8'hAE;
    localparam logic [7:0] OP_LDXAY = 8'hBE;
    localparam logic [7:0] OP_STXZ = 8'h86;
    localparam logic [7:0] OP_STXZY = 8'h96;
    localparam logic [7:0] OP_STXA = 8'h8E;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_LDX  = 4'b0010,
        PH_JLO  = 4'b0100,
        PH_JHI  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [2:0] result_kind;
        logic [15:0] bus_address;
        logic [7:0] bus_write_data;
        logic [1:0] extra_cycles;
    } t_res;

    typedef struct packed {
        logic [0:0] req_type;
        logic [7:0] opcode_byte;
        logic [7:0] operand_low;
        logic [7:0] operand_high;
        logic [7:0] read_data;
    } t_in;

    typedef struct packed {
        logic [2:0] result_kind;
        logic [15:0] bus_address;
        logic [7:0] bus_write_data;
        logic [15:0] pc_out;
        logic [7:0] x_out;
        logic [7:0] status_out;
        logic [7:0] sp_out;
        logic [1:0] extra_cycles;
        logic last_of_run;
    } t_out;
endpackage

/* src/c6502_in_if.sv */
interface c6502_in_if import c6502_pkg::*; ();
    logic valid;
    logic ready;
    t_in data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

/* src/c6502_out_if.sv */
interface c6502_out_if import c6502_pkg::*; ();
    logic valid;
    logic ready;
    t_out data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

/* src/c6502_queue.sv */
// Small result queue: holds up to four entries so that an item's whole run of
// results fits while earlier results still wait downstream.
module c6502_queue import c6502_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic [1:0] i_push_n,
    input  t_out i_push [3],
    output logic [2:0] o_free,
    output logic o_valid,
    output t_out o_data,
    input  logic i_pop
);
    t_out r_mem [4];
    logic [1:0] r_rd;
    logic [1:0] r_wr;
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;
    logic pop;

    assign pop = i_pop && (r_cnt != 3'd0);
    assign o_valid = r_cnt != 3'd0;
    assign o_data = r_mem[r_rd];
    assign o_free = 3'd4 - r_cnt;
    assign n_cnt = r_cnt + {1'b0, i_push_n} - {2'b0, pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0;
            r_wr <= '0;
            r_cnt <= '0;
        end else begin
            r_rd <= r_rd + {1'b0, pop};
            r_wr <= r_wr + i_push_n;
            r_cnt <= n_cnt;
        end
        for (int k = 0; k < 3; k++) begin
            if (k < int'(i_push_n)) begin
                r_mem[r_wr + k[1:0]] <= i_push[k];
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4) else $error("queue count beyond depth");
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, i_push_n} <= o_free + {2'b0, pop}) else $error("queue overflow");
endmodule

/* src/cpu_6502_subset_executor.sv */
// Channel | Dir | Payload
// in      | in  | req_type, opcode_byte, operand_low, operand_high, read_data
// out     | out | result_kind, bus_address, bus_write_data, pc_out, x_out,
//         |     | status_out, sp_out, extra_cycles, last_of_run
// One transaction is executed per cycle in a single pass while the queue has room; its one to three
// results enter a four-entry queue in the same edge and leave one per cycle while out_ch.ready is high.
// A new transaction is taken whenever the queue has room for three results.
// Synchronous active-low reset loads the start registers into the CPU state.
module cpu_6502_subset_executor import c6502_pkg::*; #(
    parameter logic [15:0] P_START_PC = DefStartPc
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    c6502_in_if.sink in_ch,
    c6502_out_if.source out_ch
);
    logic [15:0] r_start_pc;
    logic [7:0] r_start_sp, r_start_st, r_start_y;
    logic [15:0] r_pc, n_pc;
    logic [7:0] r_x, n_x, r_y, r_sp, n_sp, r_st, n_st, r_plo, n_plo;
    logic [15:0] r_ptr, n_ptr;
    t_phase r_ph, n_ph;
    logic r_halt, n_halt;
    logic acc;
    logic [1:0] n_cnt;
    t_res res [3];
    t_out push [3];
    logic [2:0] free;
    t_in d;
    logic [15:0] absa, absy, off, tgt, pc2;
    logic [7:0] zpy, ldv;
    logic flag, doload;

    assign d = in_ch.data;
    assign in_ch.ready = free >= 3'd3;
    assign acc = in_ch.valid && in_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pc <= P_START_PC;
            r_start_sp <= DefStartSp;
            r_start_st <= DefStartStatus;
            r_start_y <= DefStartY;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_PC: r_start_pc <= i_cfg_data;
                CFG_START_SP: r_start_sp <= i_cfg_data[7:0];
                CFG_START_STATUS: r_start_st <= i_cfg_data[7:0];
                CFG_START_Y: r_start_y <= i_cfg_data[7:0];
                default: r_start_y <= r_start_y;
            endcase
        end
    end

    always_comb begin
        absa = {d.operand_high, d.operand_low};
        zpy = d.operand_low + r_y;
        absy = absa + {8'd0, r_y};
        pc2 = r_pc + 16'd2;
        off = {{8{d.operand_low[7]}}, d.operand_low};
        tgt = pc2 + off;
        n_pc = r_pc; n_x = r_x; n_sp = r_sp; n_st = r_st; n_plo = r_plo;
        n_ptr = r_ptr; n_ph = r_ph; n_halt = r_halt;
        n_cnt = 2'd1;
        doload = 1'b0; ldv = d.read_data;
        for (int k = 0; k < 3; k++) res[k] = '{KIND_DONE, 16'd0, 8'd0, 2'd0};
        case (d.opcode_byte[7:6])
            2'd0: flag = r_st[7];
            2'd1: flag = r_st[6];
            2'd2: flag = r_st[0];
            default: flag = r_st[1];
        endcase
        if (r_halt) begin
            res[0].result_kind = KIND_HALT;
        end else if (d.req_type == 1'b1) begin
            case (r_ph)
                PH_LDX: begin doload = 1'b1; n_ph = PH_IDLE; end
                PH_JLO: begin
                    n_plo = d.read_data; n_ph = PH_JHI;
                    res[0].result_kind = KIND_READ;
                    res[0].bus_address = {r_ptr[15:8], r_ptr[7:0] + 8'd1};
                end
                PH_JHI: begin n_pc = {d.read_data, r_plo}; n_ph = PH_IDLE; end
                default: res[0].result_kind = KIND_UNEXP;
            endcase
        end else if (r_ph != PH_IDLE) begin
            res[0].result_kind = KIND_UNEXP;
        end else if (d.opcode_byte[4:0] == 5'h10) begin
            n_pc = pc2;
            if (flag == d.opcode_byte[5]) begin
                n_pc = tgt;
                res[0].extra_cycles = (tgt[15:8] != pc2[15:8]) ? 2'd2 : 2'd1;
            end
        end else begin
            case (d.opcode_byte)
                OP_CLC, OP_SEC, OP_NOP: begin
                    n_pc = r_pc + 16'd1;
                    if (d.opcode_byte == OP_CLC) n_st[0] = 1'b0;
                    if (d.opcode_byte == OP_SEC) n_st[0] = 1'b1;
                    res[0].extra_cycles = 2'd1;
                end
                OP_JMP: n_pc = absa;
                OP_JMPI: begin
                    n_pc = r_pc + 16'd3; n_ptr = absa; n_ph = PH_JLO;
                    res[0].result_kind = KIND_READ; res[0].bus_address = absa;
                end
                OP_JSR: begin
                    n_sp = r_sp - 8'd2; n_pc = absa; n_cnt = 2'd3;
                    res[0] = '{KIND_WRITE, {8'h01, r_sp}, pc2[15:8], 2'd1};
                    res[1] = '{KIND_WRITE, {8'h01, r_sp - 8'd1}, pc2[7:0], 2'd0};
                end
                OP_LDXI: begin n_pc = pc2; doload = 1'b1; ldv = d.operand_low; end
                OP_LDXZ, OP_LDXZY, OP_LDXA, OP_LDXAY: begin
                    n_ph = PH_LDX; res[0].result_kind = KIND_READ; n_pc = pc2;
                    case (d.opcode_byte)
                        OP_LDXZ: res[0].bus_address = {8'd0, d.operand_low};
                        OP_LDXZY: begin
                            res[0].bus_address = {8'd0, zpy}; res[0].extra_cycles = 2'd1;
                        end
                        OP_LDXA: begin res[0].bus_address = absa; n_pc = r_pc + 16'd3; end
                        default: begin
                            res[0].bus_address = absy; n_pc = r_pc + 16'd3;
                            res[0].extra_cycles = {1'b0, absy[15:8] != absa[15:8]};
                        end
                    endcase
                end
                OP_STXZ, OP_STXZY, OP_STXA: begin
                    n_cnt = 2'd2; n_pc = pc2;
                    res[0].result_kind = KIND_WRITE; res[0].bus_write_data = r_x;
                    case (d.opcode_byte)
                        OP_STXZ: res[0].bus_address = {8'd0, d.operand_low};
                        OP_STXZY: begin
                            res[0].bus_address = {8'd0, zpy}; res[0].extra_cycles = 2'd1;
                        end
                        default: begin res[0].bus_address = absa; n_pc = r_pc + 16'd3; end
                    endcase
                end
                default: begin n_halt = 1'b1; res[0].result_kind = KIND_HALT; end
            endcase
        end
        if (doload) begin
            n_x = ldv;
            n_st = {ldv[7], r_st[6:2], ldv == 8'd0, r_st[0]};
        end
        for (int k = 0; k < 3; k++) begin
            push[k] = '{res[k].result_kind, res[k].bus_address, res[k].bus_write_data,
                n_pc, n_x, n_st, n_sp, res[k].extra_cycles, (k + 1) == int'(n_cnt)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= r_start_pc; r_x <= 8'd0; r_y <= r_start_y; r_sp <= r_start_sp;
            r_st <= r_start_st; r_ph <= PH_IDLE; r_ptr <= '0; r_plo <= '0;
            r_halt <= 1'b0;
        end else if (acc) begin
            r_pc <= n_pc; r_x <= n_x; r_sp <= n_sp; r_st <= n_st;
            r_ph <= n_ph; r_ptr <= n_ptr; r_plo <= n_plo; r_halt <= n_halt;
        end
    end

    c6502_queue u_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push_n(acc ? n_cnt : 2'd0), .i_push(push), .o_free(free),
        .o_valid(out_ch.valid), .o_data(out_ch.data), .i_pop(out_ch.ready)
    );

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt) else $error("halt cleared");
    a_halt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && r_halt) |=> ($stable(r_pc) && $stable(r_x))) else $error("halted state moved");
    a_phase_oh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_ph)) else $error("phase not one-hot");
endmodule

/* dv/tb_cpu_6502_subset_executor.sv */
`timescale 1ns / 1ps

module tb_cpu_6502_subset_executor;
    import c6502_pkg::*;

    localparam int WatchdogLimit = 2000;
    localparam int LongHold = 60;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CfgIdxW-1:0] i_cfg_idx;
    logic [CfgDataW-1:0] i_cfg_data;

    c6502_in_if in_ch();
    c6502_out_if out_ch();

    cpu_6502_subset_executor DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    localparam logic [7:0] LegalOps [22] = '{
        8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0,
        OP_CLC, OP_SEC, OP_NOP, OP_JMP, OP_JMPI, OP_JSR, OP_LDXI,
        OP_LDXZ, OP_LDXZY, OP_LDXA, OP_LDXAY, OP_STXZ, OP_STXZY, OP_STXA
    };

    // Shadow of the configuration; it only matters at reset.
    logic [15:0] cfg_pc = DefStartPc;
    logic [7:0] cfg_sp = DefStartSp;
    logic [7:0] cfg_status = DefStartStatus;
    logic [7:0] cfg_y = DefStartY;

    logic [15:0] cpu_pc;
    logic [7:0] cpu_x, cpu_y, cpu_sp, cpu_p;
    t_phase cpu_phase;
    logic [15:0] jmp_pointer;
    logic [7:0] jmp_low;
    logic cpu_halted;

    t_out expected_results[$];
    t_out item_results[$];
    int fail_count = 0;
    int items_sent = 0;
    int results_seen = 0;
    int quiet_cycles = 0;
    bit send_idling = 1'b1;
    bit recv_idling = 1'b1;
    bit hold_request = 1'b0;
    int hold_left = 0;
    int stall_left = 0;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    task automatic add_result(input logic [2:0] kind, input logic [15:0] addr,
                              input logic [7:0] wdata, input logic [1:0] extra);
        t_out r;
        r = '0;
        r.result_kind = kind;
        r.bus_address = addr;
        r.bus_write_data = wdata;
        r.extra_cycles = extra;
        item_results.push_back(r);
    endtask

    task automatic set_x(input logic [7:0] v);
        cpu_x = v;
        cpu_p = cpu_p & 8'h7D;
        if (v == 8'h00) cpu_p[1] = 1'b1;
        if (v[7]) cpu_p[7] = 1'b1;
    endtask

    task automatic predict_results(input t_in it);
        logic [15:0] abs_addr, absy, addr, ret, target;
        logic [7:0] zpy;
        logic [1:0] extra;
        logic flag;
        abs_addr = {it.operand_high, it.operand_low};
        zpy = it.operand_low + cpu_y;
        absy = abs_addr + {8'h00, cpu_y};
        item_results.delete();
        if (cpu_halted) begin
            add_result(KIND_HALT, '0, '0, '0);
        end else if (it.req_type == 1'b1) begin
            case (cpu_phase)
                PH_LDX: begin
                    set_x(it.read_data);
                    cpu_phase = PH_IDLE;
                    add_result(KIND_DONE, '0, '0, '0);
                end
                PH_JLO: begin
                    jmp_low = it.read_data;
                    cpu_phase = PH_JHI;
                    add_result(KIND_READ, {jmp_pointer[15:8], jmp_pointer[7:0] + 8'd1}, '0, '0);
                end
                PH_JHI: begin
                    cpu_pc = {it.read_data, jmp_low};
                    cpu_phase = PH_IDLE;
                    add_result(KIND_DONE, '0, '0, '0);
                end
                default: add_result(KIND_UNEXP, '0, '0, '0);
            endcase
        end else if (cpu_phase != PH_IDLE) begin
            add_result(KIND_UNEXP, '0, '0, '0);
        end else if (it.opcode_byte[4:0] == 5'b10000) begin
            case (it.opcode_byte[7:6])
                2'd0: flag = cpu_p[7];
                2'd1: flag = cpu_p[6];
                2'd2: flag = cpu_p[0];
                default: flag = cpu_p[1];
            endcase
            cpu_pc = cpu_pc + 16'd2;
            extra = 2'd0;
            if (flag == it.opcode_byte[5]) begin
                target = cpu_pc + {{8{it.operand_low[7]}}, it.operand_low};
                extra = (target[15:8] != cpu_pc[15:8]) ? 2'd2 : 2'd1;
                cpu_pc = target;
            end
            add_result(KIND_DONE, '0, '0, extra);
        end else begin
            case (it.opcode_byte)
                OP_CLC, OP_SEC, OP_NOP: begin
                    cpu_pc = cpu_pc + 16'd1;
                    if (it.opcode_byte == OP_CLC) cpu_p[0] = 1'b0;
                    if (it.opcode_byte == OP_SEC) cpu_p[0] = 1'b1;
                    add_result(KIND_DONE, '0, '0, 2'd1);
                end
                OP_JMP: begin
                    cpu_pc = abs_addr;
                    add_result(KIND_DONE, '0, '0, '0);
                end
                OP_JMPI: begin
                    cpu_pc = cpu_pc + 16'd3;
                    jmp_pointer = abs_addr;
                    cpu_phase = PH_JLO;
                    add_result(KIND_READ, abs_addr, '0, '0);
                end
                OP_JSR: begin
                    ret = cpu_pc + 16'd2;
                    add_result(KIND_WRITE, {8'h01, cpu_sp}, ret[15:8], 2'd1);
                    cpu_sp = cpu_sp - 8'd1;
                    add_result(KIND_WRITE, {8'h01, cpu_sp}, ret[7:0], '0);
                    cpu_sp = cpu_sp - 8'd1;
                    cpu_pc = abs_addr;
                    add_result(KIND_DONE, '0, '0, '0);
                end
                OP_LDXI: begin
                    cpu_pc = cpu_pc + 16'd2;
                    set_x(it.operand_low);
                    add_result(KIND_DONE, '0, '0, '0);
                end
                OP_LDXZ, OP_LDXZY, OP_LDXA, OP_LDXAY: begin
                    extra = 2'd0;
                    case (it.opcode_byte)
                        OP_LDXZ: addr = {8'h00, it.operand_low};
                        OP_LDXZY: begin
                            addr = {8'h00, zpy};
                            extra = 2'd1;
                        end
                        OP_LDXA: addr = abs_addr;
                        default: begin
                            addr = absy;
                            extra = (absy[15:8] != abs_addr[15:8]) ? 2'd1 : 2'd0;
                        end
                    endcase
                    cpu_pc = cpu_pc + ((it.opcode_byte == OP_LDXA || it.opcode_byte == OP_LDXAY)
                                       ? 16'd3 : 16'd2);
                    cpu_phase = PH_LDX;
                    add_result(KIND_READ, addr, '0, extra);
                end
                OP_STXZ, OP_STXZY, OP_STXA: begin
                    extra = 2'd0;
                    case (it.opcode_byte)
                        OP_STXZ: addr = {8'h00, it.operand_low};
                        OP_STXZY: begin
                            addr = {8'h00, zpy};
                            extra = 2'd1;
                        end
                        default: addr = abs_addr;
                    endcase
                    cpu_pc = cpu_pc + ((it.opcode_byte == OP_STXA) ? 16'd3 : 16'd2);
                    add_result(KIND_WRITE, addr, cpu_x, extra);
                    add_result(KIND_DONE, '0, '0, '0);
                end
                default: begin
                    cpu_halted = 1'b1;
                    add_result(KIND_HALT, '0, '0, '0);
                end
            endcase
        end
        foreach (item_results[k]) begin
            item_results[k].pc_out = cpu_pc;
            item_results[k].x_out = cpu_x;
            item_results[k].status_out = cpu_p;
            item_results[k].sp_out = cpu_sp;
            item_results[k].last_of_run = (k == item_results.size() - 1);
            expected_results.push_back(item_results[k]);
        end
    endtask

    // Called right after a rising edge; leaves valid high after the transaction.
    task automatic send_item(input t_in it);
        if (send_idling && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_results(it);
        items_sent++;
    endtask

    task automatic stop_sending();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain_results();
        stop_sending();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_in make_insn(input logic [7:0] op, input logic [7:0] lo,
                                      input logic [7:0] hi);
        t_in it;
        it.req_type = 1'b0;
        it.opcode_byte = op;
        it.operand_low = lo;
        it.operand_high = hi;
        it.read_data = 8'($urandom);
        return it;
    endfunction

    function automatic t_in make_data(input logic [7:0] rd);
        t_in it;
        it.req_type = 1'b1;
        it.opcode_byte = 8'($urandom);
        it.operand_low = 8'($urandom);
        it.operand_high = 8'($urandom);
        it.read_data = rd;
        return it;
    endfunction

    // An occasional transaction of random type tests the unexpected-item paths.
    function automatic t_in make_random_item();
        t_in it;
        if ($urandom_range(0, 19) == 0) begin
            it = make_insn(LegalOps[$urandom_range(0, 21)], 8'($urandom), 8'($urandom));
            it.req_type = 1'($urandom);
            return it;
        end
        if (cpu_phase != PH_IDLE) return make_data(8'($urandom));
        return make_insn(LegalOps[$urandom_range(0, 21)], 8'($urandom), 8'($urandom));
    endfunction

    task automatic write_config(input logic [1:0] idx, input logic [15:0] value);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_START_PC: cfg_pc = value;
            CFG_START_SP: cfg_sp = value[7:0];
            CFG_START_STATUS: cfg_status = value[7:0];
            default: cfg_y = value[7:0];
        endcase
        @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out e;
        t_out a;
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles = 0;
        end else if (i_rst_n) begin
            quiet_cycles++;
            if (quiet_cycles >= WatchdogLimit) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            a = out_ch.data;
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("result_kind: expected none, got %0h", a.result_kind);
                fail_count++;
            end else begin
                e = expected_results.pop_front();
                check_field("result_kind", e.result_kind, a.result_kind);
                check_field("bus_address", e.bus_address, a.bus_address);
                check_field("bus_write_data", e.bus_write_data, a.bus_write_data);
                check_field("pc_out", e.pc_out, a.pc_out);
                check_field("x_out", e.x_out, a.x_out);
                check_field("status_out", e.status_out, a.status_out);
                check_field("sp_out", e.sp_out, a.sp_out);
                check_field("extra_cycles", e.extra_cycles, a.extra_cycles);
                check_field("last_of_run", e.last_of_run, a.last_of_run);
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = LongHold - 1;
            out_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end else if (recv_idling && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    task automatic test_config();
        write_config(CFG_START_PC, 16'hFFFF);
        write_config(CFG_START_SP, 16'h0000);
        write_config(CFG_START_STATUS, 16'h00FF);
        write_config(CFG_START_Y, 16'h00FF);
    endtask

    task automatic test_flags_and_jumps();
        send_item(make_insn(OP_SEC, 8'h00, 8'h00));
        send_item(make_insn(8'hB0, 8'h7F, 8'h00));
        send_item(make_insn(OP_CLC, 8'hFF, 8'hFF));
        send_item(make_insn(8'h90, 8'h80, 8'hFF));
        send_item(make_insn(OP_NOP, 8'h00, 8'h00));
        send_item(make_insn(OP_JMP, 8'hF0, 8'h00));
        send_item(make_insn(8'hB0, 8'h20, 8'h00));
        send_item(make_insn(8'h90, 8'h7F, 8'h00));
        send_item(make_insn(8'h10, 8'h01, 8'h00));
        send_item(make_insn(8'h30, 8'h01, 8'h00));
        send_item(make_insn(8'h50, 8'hFE, 8'h00));
        send_item(make_insn(8'h70, 8'hFE, 8'h00));
        send_item(make_insn(8'hD0, 8'h10, 8'h00));
        send_item(make_insn(8'hF0, 8'h10, 8'h00));
        send_item(make_insn(OP_JMPI, 8'hFF, 8'h12));
        send_item(make_data(8'h34));
        send_item(make_data(8'hFF));
        send_item(make_insn(OP_JSR, 8'h00, 8'hFF));
    endtask

    task automatic test_index_x();
        send_item(make_insn(OP_LDXI, 8'h00, 8'h00));
        send_item(make_insn(OP_LDXI, 8'h80, 8'h00));
        send_item(make_insn(OP_STXZ, 8'hFF, 8'h00));
        send_item(make_insn(OP_LDXZ, 8'h00, 8'h00));
        send_item(make_insn(OP_NOP, 8'h00, 8'h00));
        send_item(make_data(8'h7F));
        send_item(make_insn(OP_LDXZY, 8'hFF, 8'h00));
        send_item(make_data(8'h00));
        send_item(make_insn(OP_LDXA, 8'hFF, 8'hFF));
        send_item(make_data(8'hFF));
        send_item(make_insn(OP_LDXAY, 8'hFF, 8'h00));
        send_item(make_data(8'h80));
        send_item(make_insn(OP_STXZY, 8'h80, 8'h00));
        send_item(make_insn(OP_STXA, 8'hCD, 8'hAB));
        send_item(make_data(8'h55));
    endtask

    task automatic test_random(input int count);
        repeat (count) send_item(make_random_item());
    endtask

    task automatic test_backpressure();
        hold_request = 1'b1;
        repeat (20) send_item(make_random_item());
        drain_results();
        test_random(10);
        drain_results();
    endtask

    task automatic test_halt();
        send_item(make_insn(8'h00, 8'h00, 8'h00));
        repeat (4) send_item(make_random_item());
        send_item(make_data(8'h12));
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        cpu_pc = DefStartPc;
        cpu_x = 8'h00;
        cpu_y = DefStartY;
        cpu_sp = DefStartSp;
        cpu_p = DefStartStatus;
        cpu_phase = PH_IDLE;
        jmp_pointer = '0;
        jmp_low = '0;
        cpu_halted = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_config();
        test_flags_and_jumps();
        test_index_x();
        drain_results();
        write_config(CFG_START_PC, 16'h0000);
        write_config(CFG_START_SP, 16'h00FF);
        test_random(200);
        drain_results();
        write_config(CFG_START_STATUS, 16'h0000);
        write_config(CFG_START_Y, 16'h0000);
        test_backpressure();
        test_random(200);
        send_idling = 1'b0;
        recv_idling = 1'b0;
        test_random(40);
        test_halt();
        stop_sending();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("Sent %0d transactions (flags, branches, jumps, JSR, LDX/STX modes, halt)",
                 items_sent);
        $display("and checked %0d results under random and long receiver stalls.",
                 results_seen);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

/* sim.f */
src/c6502_pkg.sv
src/c6502_in_if.sv
src/c6502_out_if.sv
src/c6502_queue.sv
src/cpu_6502_subset_executor.sv
dv/tb_cpu_6502_subset_executor.sv
